### sv/ptc_pkg.sv
package ptc_pkg;

  localparam int unsigned ErrW     = 16;
  localparam int unsigned ModeW    = 4;
  localparam int unsigned QualW    = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LimW     = 15;
  localparam int unsigned TurnW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_OFFSET_LIMIT = 3'd3,
    CFG_SLEW_LIMIT   = 3'd4,
    CFG_QUALITY_MIN  = 3'd5,
    CFG_LOST_MODE_ID = 3'd6
  } cfg_idx_e;

  localparam logic [LimW-1:0]  OffsetLimitRst = 15'h7fff;
  localparam logic [ModeW-1:0] LostModeRst    = 4'hf;

  // input item as packed in s_axis_tdata, lowest bits last in this list
  typedef struct packed {
    logic [1:0]              pad;
    logic                    app_halted;
    logic                    out_permit;
    logic [QualW-1:0]        sig_qual;
    logic [ModeW-1:0]        mode_id;
    logic signed [ErrW-1:0]  err_rate;
    logic signed [ErrW-1:0]  line_error;
  } in_item_t;

  typedef struct packed {
    logic [6:0]              pad;
    logic                    held;
    logic signed [TurnW-1:0] turn_delta;
  } out_item_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic hold;
    logic clr_prev;
  } item_ctl_t;

endpackage

### sv/pid_turn_controller_core.sv
// A result is valid on the master side once its accepted input transaction has passed
// through five register stages, input through output register.
// Throughput: one transaction per cycle; each stage stalls only when the stage after it
// is full and stalled.
// Reset: clears the pipeline, the integrator, previous output and last mode, and
// returns all configuration registers to their defaults.
module pid_turn_controller_core #(
  parameter int OUTPUT_SCALE = 100,
  parameter int TURN_LIMIT   = 1000,
  parameter int INTEG_LIMIT  = 2000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ptc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // line_error[15:0], err_rate[31:16], mode_id[35:32], sig_qual[51:36],
  // out_permit[52], app_halted[53], zero pad[55:54]
  input  logic [ptc_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // turn_delta[15:0], held[16], zero pad[23:17]
  output logic [ptc_pkg::OutDataW-1:0]   m_axis_tdata
);
  import ptc_pkg::*;

  localparam int IW    = $clog2(INTEG_LIMIT + 1) + 1;
  localparam int ISW   = ((IW > ErrW) ? IW : ErrW) + 1;
  localparam int PW    = 2 * GainW;
  localparam int PIW   = GainW + IW;
  localparam int SW    = PW + 2;
  localparam longint unsigned SAT_MAG = 64'd32768 * OUTPUT_SCALE;
  localparam int MAG_W = $clog2(SAT_MAG);
  localparam int LSH   = $clog2(OUTPUT_SCALE);
  localparam int KSH   = MAG_W + LSH;
  localparam logic [MAG_W:0] RECIP =
      (MAG_W+1)'(((64'd1 << KSH) + OUTPUT_SCALE - 1) / OUTPUT_SCALE);
  localparam logic signed [ISW-1:0] ILIM = ISW'(INTEG_LIMIT);
  localparam logic signed [17:0]    TLIM = 18'(TURN_LIMIT);

  // configuration
  logic signed [GainW-1:0] kp_q, ki_q, kd_q;
  logic [LimW-1:0]         off_lim_q, slew_lim_q;
  logic [QualW-1:0]        qual_min_q;
  logic [ModeW-1:0]        lost_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      off_lim_q   <= OffsetLimitRst;
      slew_lim_q  <= '0;
      qual_min_q  <= '0;
      lost_mode_q <= LostModeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN:    kp_q        <= cfg_data_i;
        CFG_INTEG_GAIN:   ki_q        <= cfg_data_i;
        CFG_DERIV_GAIN:   kd_q        <= cfg_data_i;
        CFG_OFFSET_LIMIT: off_lim_q   <= cfg_data_i[LimW-1:0];
        CFG_SLEW_LIMIT:   slew_lim_q  <= cfg_data_i[LimW-1:0];
        CFG_QUALITY_MIN:  qual_min_q  <= cfg_data_i;
        CFG_LOST_MODE_ID: lost_mode_q <= cfg_data_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_acc;

  assign rdy5          = !v5_q || m_axis_tready;
  assign rdy4          = !v4_q || rdy5;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign in_acc        = s_axis_tvalid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage 1: hold decode and integrator, state updated per accepted item
  in_item_t                 in_item;
  logic signed [IW-1:0]     integ_q, integ_d, integ_base;
  logic [ModeW-1:0]         seen_mode_q;
  logic signed [ISW-1:0]    integ_sum;
  logic                     hold, mode_chg;

  assign in_item = in_item_t'(s_axis_tdata);

  always_comb begin
    hold = !in_item.out_permit || (in_item.sig_qual < qual_min_q) ||
           (in_item.mode_id == lost_mode_q) || in_item.app_halted;
    mode_chg   = seen_mode_q != in_item.mode_id;
    integ_base = mode_chg ? '0 : integ_q;
    integ_sum  = ISW'(integ_base) + ISW'(in_item.line_error);
    if (hold || (ki_q == '0)) begin
      integ_d = '0;
    end else if (integ_sum > ILIM) begin
      integ_d = IW'(ILIM);
    end else if (integ_sum < -ILIM) begin
      integ_d = IW'(-ILIM);
    end else begin
      integ_d = IW'(integ_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      seen_mode_q <= '0;
    end else if (in_acc) begin
      integ_q     <= integ_d;
      seen_mode_q <= in_item.mode_id;
    end
  end

  logic signed [ErrW-1:0] s1_err_q, s1_rate_q;
  logic signed [IW-1:0]   s1_integ_q;
  item_ctl_t              s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_err_q          <= in_item.line_error;
      s1_rate_q         <= in_item.err_rate;
      s1_integ_q        <= integ_d;
      s1_ctl_q.hold     <= hold;
      s1_ctl_q.clr_prev <= hold || mode_chg;
    end
  end

  // stage 2: the three products
  logic signed [PW-1:0]  s2_p_q, s2_d_q;
  logic signed [PIW-1:0] s2_i_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_p_q   <= kp_q * s1_err_q;
      s2_i_q   <= ki_q * s1_integ_q;
      s2_d_q   <= kd_q * s1_rate_q;
      s2_ctl_q <= s1_ctl_q;
    end
  end

  // stage 3: exact sum, split into sign and magnitude, saturation check
  logic signed [SW-1:0] pid_sum;
  logic [SW-1:0]        pid_mag;
  logic [MAG_W-1:0]     s3_mag_q;
  logic                 s3_neg_q, s3_sat_q;

  assign pid_sum = SW'(s2_p_q) + SW'(s2_i_q) + SW'(s2_d_q);
  assign pid_mag = pid_sum[SW-1] ? SW'(-pid_sum) : SW'(pid_sum);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_mag_q <= pid_mag[MAG_W-1:0];
      s3_neg_q <= pid_sum[SW-1];
      s3_sat_q <= pid_mag >= SW'(SAT_MAG);
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // stage 4: magnitude / scale by reciprocal multiply, exact for every magnitude below SAT_MAG
  logic [2*MAG_W:0] quot_prod;
  logic [14:0]      s4_quot_q;
  logic             s4_neg_q, s4_sat_q;

  assign quot_prod = (2*MAG_W+1)'(s3_mag_q) * (2*MAG_W+1)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      s4_quot_q <= quot_prod[KSH+14:KSH];
      s4_neg_q  <= s3_neg_q;
      s4_sat_q  <= s3_sat_q;
      s4_ctl_q  <= s3_ctl_q;
    end
  end

  // stage 5: offset clamp, slew limit, turn clamp, zero turn on hold
  logic signed [16:0]      v_div, v_off, off_lim;
  logic signed [17:0]      prev_base, slew, v_slew, v_turn, slew_diff;
  logic signed [TurnW-1:0] prev_q, turn_d;
  logic signed [TurnW-1:0] out_turn_q;
  logic                    out_held_q;

  always_comb begin
    off_lim = 17'(off_lim_q);
    if (s4_sat_q) begin
      v_div = s4_neg_q ? -17'sd32768 : 17'sd32767;
    end else begin
      v_div = s4_neg_q ? -17'(s4_quot_q) : 17'(s4_quot_q);
    end
    if (v_div > off_lim) begin
      v_off = off_lim;
    end else if (v_div < -off_lim) begin
      v_off = -off_lim;
    end else begin
      v_off = v_div;
    end
    prev_base = s4_ctl_q.clr_prev ? '0 : 18'(prev_q);
    slew      = 18'(slew_lim_q);
    slew_diff = 18'(v_off) - prev_base;
    v_slew    = 18'(v_off);
    if (slew_lim_q != '0) begin
      if (slew_diff > slew) begin
        v_slew = prev_base + slew;
      end else if (slew_diff < -slew) begin
        v_slew = prev_base - slew;
      end
    end
    if (v_slew > TLIM) begin
      v_turn = TLIM;
    end else if (v_slew < -TLIM) begin
      v_turn = -TLIM;
    end else begin
      v_turn = v_slew;
    end
    turn_d = s4_ctl_q.hold ? '0 : TurnW'(v_turn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (rdy5 && v4_q) begin
      prev_q <= turn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      out_turn_q <= turn_d;
      out_held_q <= s4_ctl_q.hold;
    end
  end

  out_item_t out_item;

  always_comb begin
    out_item            = '0;
    out_item.turn_delta = out_turn_q;
    out_item.held       = out_held_q;
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = out_item;

`ifndef SYNTHESIS
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= IW'(ILIM)) && (integ_q >= IW'(-ILIM)))
    else $error("integrator out of range");

  a_prev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (18'(prev_q) <= TLIM) && (18'(prev_q) >= -TLIM))
    else $error("previous turn out of range");

  a_held_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && out_held_q) |-> (out_turn_q == '0))
    else $error("held result with nonzero turn");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> ((18'(out_turn_q) <= TLIM) && (18'(out_turn_q) >= -TLIM)))
    else $error("turn result beyond turn limit");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v5_q |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_prev_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rdy5 && v4_q) |-> (prev_q == out_turn_q))
    else $error("previous turn differs from last result");
`endif

endmodule
